### src/pmk_pkg.sv
// Shared types, constants and arithmetic helpers for the point-mass kinematics block.
`timescale 1ns / 1ps
package pmk_pkg;

   // Field and storage widths.
   localparam int DIMS       = 3;
   localparam int DATA_W     = 32;
   localparam int MASS_W     = 16;
   localparam int AXES_W     = 2;
   localparam int DT_W       = 31;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam int PROD_W     = 64;
   localparam int WIDE_W     = 96;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_MASS  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_AXES = 1'd1;

   // Request kinds.
   localparam logic REQ_FORCE = 1'b0;
   localparam logic REQ_STEP  = 1'b1;

   // Largest magnitude kept for the half acceleration term.
   localparam logic [WIDE_W-1:0] TERM_CAP = WIDE_W'(1) << 60;

   typedef logic signed [DATA_W-1:0] q_type;

   // Status of the iterative divider.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Magnitude of a signed word; the most negative value maps to 2^31.
   function automatic logic [DATA_W-1:0] mag32(input q_type x);
      logic [DATA_W-1:0] r;
      r = x[DATA_W-1] ? (~x + 1'b1) : x;
      return r;
   endfunction

   // Clamp a wide signed sum to the 32-bit range.
   function automatic q_type sat32(input logic signed [PROD_W-1:0] v);
      q_type r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

### src/pmk_div.sv
// Restoring divider, one quotient bit per cycle, 32-bit dividend by 16-bit divisor.
`timescale 1ns / 1ps
module pmk_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pmk_pkg::DATA_W-1:0]    dividend,
   input  logic [pmk_pkg::MASS_W-1:0]    divisor,
   output logic [pmk_pkg::DATA_W-1:0]    quotient,
   output pmk_pkg::div_status_type       status
);
   import pmk_pkg::*;

   localparam int CNT_W = $clog2(DATA_W);

   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [MASS_W-1:0] rem_ff, rem_in;
   logic [MASS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [MASS_W:0]   shifted;
   logic [MASS_W:0]   diff;
   logic              fits;

   // One restoring step: bring down the next dividend bit and try the subtract.
   always_comb begin
      shifted = {rem_ff, quo_ff[DATA_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      fits    = (shifted >= {1'b0, dvs_ff});
   end

   // Sequencing of the 32 steps.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DATA_W-2:0], fits};
         rem_in = fits ? diff[MASS_W-1:0] : shifted[MASS_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

### src/point_mass_kinematics_step.sv
// Point-mass kinematics: force accumulation and constant-acceleration time steps.
// An apply-force item runs each active axis through the serial divider; a time-step item runs
// each active axis through the single shared 32x32 multiplier. The input stalls until the
// item is finished, and the result becomes valid in the same cycle that the input is free
// again; the result register lets the next item enter while the last result waits. Synchronous
// reset clears kinematic and control state to zero, point_mass to 1 and active_axes to 2.
`timescale 1ns / 1ps
module point_mass_kinematics_step #(
   parameter int AXES      = 3,
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // Configuration writes.
   input  logic                              csr_we,
   input  logic [pmk_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pmk_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // Request channel.
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_type,
   input  logic signed [pmk_pkg::DATA_W-1:0] req_force_x,
   input  logic signed [pmk_pkg::DATA_W-1:0] req_force_y,
   input  logic signed [pmk_pkg::DATA_W-1:0] req_force_z,
   input  logic [pmk_pkg::DT_W-1:0]          req_step_length,
   // Result channel.
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [pmk_pkg::DATA_W-1:0] rsp_pos_x,
   output logic signed [pmk_pkg::DATA_W-1:0] rsp_pos_y,
   output logic signed [pmk_pkg::DATA_W-1:0] rsp_pos_z,
   output logic signed [pmk_pkg::DATA_W-1:0] rsp_vel_x,
   output logic signed [pmk_pkg::DATA_W-1:0] rsp_vel_y,
   output logic signed [pmk_pkg::DATA_W-1:0] rsp_vel_z,
   output logic signed [pmk_pkg::DATA_W-1:0] rsp_acc_x,
   output logic signed [pmk_pkg::DATA_W-1:0] rsp_acc_y,
   output logic signed [pmk_pkg::DATA_W-1:0] rsp_acc_z
);
   import pmk_pkg::*;

   localparam int               HALF_SHIFT = 2 * FRAC_BITS + 1;
   localparam logic [AXES_W-1:0] AXES_LIM  = AXES_W'(AXES);

   // Sequencer state codes.
   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DIV_START = 4'd1;
   localparam logic [3:0] S_DIV_WAIT  = 4'd2;
   localparam logic [3:0] S_ACC       = 4'd3;
   localparam logic [3:0] S_MUL_V     = 4'd4;
   localparam logic [3:0] S_MUL_A     = 4'd5;
   localparam logic [3:0] S_MUL_LO    = 4'd6;
   localparam logic [3:0] S_MUL_HI    = 4'd7;
   localparam logic [3:0] S_HALF      = 4'd8;
   localparam logic [3:0] S_POS       = 4'd9;
   localparam logic [3:0] S_DONE      = 4'd10;

   // Configuration registers.
   logic [MASS_W-1:0] mass_ff, mass_in;
   logic [AXES_W-1:0] axes_ff, axes_in;

   // Kinematic state per axis.
   q_type pos_ff [DIMS], pos_in [DIMS];
   q_type vel_ff [DIMS], vel_in [DIMS];
   q_type acc_ff [DIMS], acc_in [DIMS];

   // Captured request.
   q_type             force_ff [DIMS], force_in [DIMS];
   logic [DT_W-1:0]   dt_ff, dt_in;
   logic [AXES_W-1:0] n_ff, n_in;
   logic [AXES_W-1:0] ax_ff, ax_in;
   logic [3:0]        state_ff, state_in;

   // Shared multiplier and working registers.
   logic [DATA_W-1:0]        mul_a;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic [PROD_W-1:0]        vdt_ff, vdt_in;
   logic [PROD_W-1:0]        m_ff, m_in;
   logic [WIDE_W-1:0]        wide_ff, wide_in;
   logic signed [PROD_W-1:0] psum_ff, psum_in;

   // Result register.
   logic  rsp_valid_ff, rsp_valid_in;
   q_type out_ff [3*DIMS], out_in [3*DIMS];

   // Divider hookup.
   logic                div_start;
   logic [DATA_W-1:0]   div_quo;
   div_status_type      div_status;
   logic [MASS_W-1:0]   mass_eff;

   // Helper terms.
   logic                     req_xfer;
   logic [AXES_W-1:0]        n_req;
   logic                     last_axis;
   logic                     v_neg, a_neg;
   logic signed [PROD_W-1:0] q_term;
   logic [WIDE_W-1:0]        half_raw;
   logic [WIDE_W-1:0]        half_cap;
   logic signed [PROD_W-1:0] half_term;
   logic [PROD_W-1:0]        adt;
   logic signed [PROD_W-1:0] adt_term;
   logic signed [PROD_W-1:0] vdt_term;

   assign mass_eff = (mass_ff == '0) ? MASS_W'(1) : mass_ff;

   pmk_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag32(force_ff[ax_ff])),
      .divisor  (mass_eff),
      .quotient (div_quo),
      .status   (div_status)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign n_req     = (axes_ff > AXES_LIM) ? AXES_LIM : axes_ff;
   assign last_axis = (ax_ff == n_ff - 1'b1);
   assign div_start = (state_ff == S_DIV_START);

   // Arithmetic terms for the current axis.
   always_comb begin
      v_neg    = vel_ff[ax_ff][DATA_W-1];
      a_neg    = acc_ff[ax_ff][DATA_W-1];
      q_term   = force_ff[ax_ff][DATA_W-1] ? -$signed({32'b0, div_quo})
                                           : $signed({32'b0, div_quo});
      half_raw = wide_ff >> HALF_SHIFT;
      half_cap = (half_raw > TERM_CAP) ? TERM_CAP : half_raw;
      half_term = a_neg ? -$signed(half_cap[PROD_W-1:0]) : $signed(half_cap[PROD_W-1:0]);
      adt      = m_ff >> FRAC_BITS;
      adt_term = a_neg ? -$signed(adt) : $signed(adt);
      vdt_term = v_neg ? -$signed(vdt_ff) : $signed(vdt_ff);
   end

   // Multiplier operand select; the second operand is always the step length.
   always_comb begin
      case (state_ff)
         S_MUL_V:  mul_a = mag32(vel_ff[ax_ff]);
         S_MUL_A:  mul_a = mag32(acc_ff[ax_ff]);
         S_MUL_LO: mul_a = prod_ff[DATA_W-1:0];
         S_MUL_HI: mul_a = m_ff[PROD_W-1:DATA_W];
         default:  mul_a = '0;
      endcase
      prod_in = PROD_W'(mul_a) * PROD_W'({1'b0, dt_ff});
   end

   // Sequencer and datapath next values.
   always_comb begin
      mass_in  = mass_ff;
      axes_in  = axes_ff;
      pos_in   = pos_ff;
      vel_in   = vel_ff;
      acc_in   = acc_ff;
      force_in = force_ff;
      dt_in    = dt_ff;
      n_in     = n_ff;
      ax_in    = ax_ff;
      state_in = state_ff;
      vdt_in   = vdt_ff;
      m_in     = m_ff;
      wide_in  = wide_ff;
      psum_in  = psum_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_in   = out_ff;

      // Configuration writes.
      if (csr_we) begin
         case (csr_index)
            CSR_POINT_MASS:  mass_in = csr_wdata[MASS_W-1:0];
            CSR_ACTIVE_AXES: axes_in = csr_wdata[AXES_W-1:0];
            default:         ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               force_in[0] = req_force_x;
               force_in[1] = req_force_y;
               force_in[2] = req_force_z;
               dt_in       = req_step_length;
               n_in        = n_req;
               ax_in       = '0;
               if (n_req == '0) begin
                  state_in = S_DONE;
               end else if (req_type == REQ_FORCE) begin
                  state_in = S_DIV_START;
               end else begin
                  state_in = S_MUL_V;
               end
            end
         end
         S_DIV_START: begin
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_status.done) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            acc_in[ax_ff] = sat32($signed({{32{acc_ff[ax_ff][DATA_W-1]}}, acc_ff[ax_ff]})
                                  + q_term);
            if (last_axis) begin
               state_in = S_DONE;
            end else begin
               ax_in    = ax_ff + 1'b1;
               state_in = S_DIV_START;
            end
         end
         S_MUL_V: begin
            state_in = S_MUL_A;
         end
         S_MUL_A: begin
            // Product holds |v|*dt.
            vdt_in   = prod_ff >> FRAC_BITS;
            state_in = S_MUL_LO;
         end
         S_MUL_LO: begin
            // Product holds |a|*dt.
            m_in     = prod_ff;
            state_in = S_MUL_HI;
         end
         S_MUL_HI: begin
            // Product holds the low half of |a|*dt*dt.
            wide_in  = WIDE_W'(prod_ff);
            state_in = S_HALF;
         end
         S_HALF: begin
            // Add the high partial product and start the position sum.
            wide_in  = wide_ff + (WIDE_W'(prod_ff) << DATA_W);
            psum_in  = $signed({{32{pos_ff[ax_ff][DATA_W-1]}}, pos_ff[ax_ff]}) + vdt_term;
            state_in = S_POS;
         end
         S_POS: begin
            pos_in[ax_ff] = sat32(psum_ff + half_term);
            vel_in[ax_ff] = sat32($signed({{32{vel_ff[ax_ff][DATA_W-1]}}, vel_ff[ax_ff]})
                                  + adt_term);
            if (last_axis) begin
               state_in = S_DONE;
            end else begin
               ax_in    = ax_ff + 1'b1;
               state_in = S_MUL_V;
            end
         end
         S_DONE: begin
            // Load the result register once it is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               for (int i = 0; i < DIMS; i++) begin
                  out_in[i]          = pos_ff[i];
                  out_in[DIMS + i]   = vel_ff[i];
                  out_in[2*DIMS + i] = acc_ff[i];
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mass_ff      <= MASS_W'(1);
         axes_ff      <= AXES_W'(2);
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         ax_ff        <= '0;
         n_ff         <= '0;
         for (int i = 0; i < DIMS; i++) begin
            pos_ff[i] <= '0;
            vel_ff[i] <= '0;
            acc_ff[i] <= '0;
         end
      end else begin
         mass_ff      <= mass_in;
         axes_ff      <= axes_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ax_ff        <= ax_in;
         n_ff         <= n_in;
         pos_ff       <= pos_in;
         vel_ff       <= vel_in;
         acc_ff       <= acc_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      force_ff <= force_in;
      dt_ff    <= dt_in;
      prod_ff  <= prod_in;
      vdt_ff   <= vdt_in;
      m_ff     <= m_in;
      wide_ff  <= wide_in;
      psum_ff  <= psum_in;
      out_ff   <= out_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pos_x = out_ff[0];
   assign rsp_pos_y = out_ff[1];
   assign rsp_pos_z = out_ff[2];
   assign rsp_vel_x = out_ff[3];
   assign rsp_vel_y = out_ff[4];
   assign rsp_vel_z = out_ff[5];
   assign rsp_acc_x = out_ff[6];
   assign rsp_acc_y = out_ff[7];
   assign rsp_acc_z = out_ff[8];

endmodule
